>>> hdl/ret_pkg.sv
package ret_pkg;

  // Frame geometry.
  localparam int IMG_WIDTH  = 188;
  localparam int IMG_HEIGHT = 120;

  // Field widths.
  localparam int PIX_W  = 8;
  localparam int COL_W  = 8;
  localparam int ROW_W  = 7;
  localparam int CNT_W  = 7;
  localparam int THR_W  = 8;
  localparam int STEP_W = 4;

  // Scan column counter is one bit wider so that col + step + 1 never wraps.
  localparam int SCAN_W = COL_W + 1;

  // Row store holds two banks of one row each.
  localparam int STORE_DEPTH = 2 * IMG_WIDTH;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int FC_AW       = $clog2(IMG_HEIGHT);

  // The ratio test compares the difference scaled by 2**RATIO_SH.
  localparam int RATIO_SH = 8;

  // Start column sum 4*center + 3*start + width, then a divide by ten done as a
  // multiply by a scaled reciprocal. The reciprocal is exact for sums below 16384.
  localparam int SUM_W     = $clog2(7 * ((1 << COL_W) - 1) + IMG_WIDTH + 1);
  localparam int DIV_SH    = 15;
  localparam int DIV_MUL   = ((1 << DIV_SH) + 9) / 10;
  localparam int DIV_MUL_W = $clog2(DIV_MUL + 1);
  localparam int PROD_W    = SUM_W + DIV_MUL_W;

  localparam logic [COL_W-1:0] MID_COL    = COL_W'(IMG_WIDTH / 2);
  localparam logic [COL_W-1:0] LAST_COL   = COL_W'(IMG_WIDTH - 1);
  localparam logic [ROW_W-1:0] BOTTOM_ROW = ROW_W'(IMG_HEIGHT - 1);
  localparam logic [CNT_W-1:0] CNT_MAX    = '1;

  // Reset values of the configuration registers.
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(17);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(3);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_STEP      = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row_index;
    logic             row_last;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] left_edge;
    logic [COL_W-1:0] right_edge;
    logic [COL_W-1:0] center;
    logic             left_found;
    logic             right_found;
    logic [CNT_W-1:0] left_count;
    logic [CNT_W-1:0] right_count;
  } out_t;

endpackage

>>> hdl/ret_edge_cmp.sv
// Difference over sum ratio test in integer form:
// edge when |a - b| * 256 > threshold * (a + b).
module ret_edge_cmp (
  input  logic [ret_pkg::PIX_W-1:0] pix_a,
  input  logic [ret_pkg::PIX_W-1:0] pix_b,
  input  logic [ret_pkg::THR_W-1:0] thr,
  output logic                      hit
);

  localparam int CMP_W = ret_pkg::PIX_W + ret_pkg::THR_W + 1;

  logic [ret_pkg::PIX_W-1:0] diff;
  logic [ret_pkg::PIX_W:0]   psum;
  logic [CMP_W-1:0]          lhs;
  logic [CMP_W-1:0]          rhs;

  always_comb begin
    diff = (pix_a > pix_b) ? (pix_a - pix_b) : (pix_b - pix_a);
    psum = {1'b0, pix_a} + {1'b0, pix_b};
    lhs  = CMP_W'(diff) << ret_pkg::RATIO_SH;
    rhs  = CMP_W'(thr) * CMP_W'(psum);
    hit  = (lhs > rhs);
  end

endmodule

>>> hdl/row_edge_tracker_top.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall   ret_pkg::in_t (pixel, column, row, row end)
// out_      output     out_valid / out_stall ret_pkg::out_t (edges, center, hit counts)
// cfg_      input      cfg_we                cfg_idx selects threshold or step, cfg_wdata
//
// Pixel transactions that do not end a row leave the block idle, so a row streams in
// at one pixel per clock while no scan runs. A row end starts the scan: S_FC, S_SUM
// and S_DIV fetch the stored center and form the start column, then each scan position
// takes a row buffer read and then the shared edge comparator, and S_DONE posts the
// result. in_stall stays high for the whole scan, up to the posting of the result.
// The result waits in an output register; a stalled result holds off only the next
// row end. Reset is synchronous and active low; it clears the center store valid
// bits at once, so no clearing pass follows reset. The row buffer is not cleared.

module row_edge_tracker_top (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  ret_pkg::in_t                  in_data,

  output logic                          out_valid,
  input  logic                          out_stall,
  output ret_pkg::out_t                 out_data,

  input  logic                          cfg_we,
  input  logic [ret_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ret_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FC,
    S_SUM,
    S_DIV,
    S_LRD,
    S_LCMP,
    S_RRD,
    S_RCMP,
    S_DONE
  } state_t;

  state_t state_r;

  // Configuration.
  logic [ret_pkg::THR_W-1:0]  thr_r;
  logic [ret_pkg::STEP_W-1:0] step_cfg_r;
  logic [ret_pkg::STEP_W-1:0] step_eff;

  // Per-row scan context.
  logic [ret_pkg::STEP_W-1:0] step_r;
  logic [ret_pkg::ROW_W-1:0]  row_r;
  logic                       bank_r;
  logic                       bottom_r;
  logic [ret_pkg::COL_W-1:0]  start_r;
  logic [ret_pkg::SUM_W-1:0]  sum_r;
  logic [ret_pkg::SCAN_W-1:0] c_r;
  logic [ret_pkg::COL_W-1:0]  left_r;
  logic [ret_pkg::COL_W-1:0]  right_r;
  logic                       lf_r;
  logic                       rf_r;
  logic [ret_pkg::CNT_W-1:0]  lhits_r;
  logic [ret_pkg::CNT_W-1:0]  rhits_r;
  logic                       fc_hit_r;

  logic                       out_valid_r;
  ret_pkg::out_t              out_data_r;

  // Memories.
  logic [ret_pkg::PIX_W-1:0]  store_mem [ret_pkg::STORE_DEPTH];
  logic [ret_pkg::PIX_W-1:0]  rd_a_r;
  logic [ret_pkg::PIX_W-1:0]  rd_b_r;
  logic [ret_pkg::COL_W-1:0]  fc_mem [ret_pkg::IMG_HEIGHT];
  logic [ret_pkg::COL_W-1:0]  fc_rd_r;
  logic [ret_pkg::IMG_HEIGHT-1:0] fc_vld_r;

  // Combinational helpers.
  logic                          in_acc;
  logic                          row_ok;
  logic                          col_ok;
  logic                          wr_en;
  logic [ret_pkg::STORE_AW-1:0]  wr_addr;
  logic [ret_pkg::STORE_AW-1:0]  bank_base;
  logic [ret_pkg::SCAN_W-1:0]    step_ext;
  logic [ret_pkg::SCAN_W-1:0]    gap;
  logic [ret_pkg::SCAN_W-1:0]    col_b;
  logic [ret_pkg::STORE_AW-1:0]  rd_addr_a;
  logic [ret_pkg::STORE_AW-1:0]  rd_addr_b;
  logic                          left_more;
  logic                          right_more;
  logic                          edge_hit;
  logic [ret_pkg::COL_W-1:0]     fc_eff;
  logic [ret_pkg::SUM_W-1:0]     sum_nxt;
  logic [ret_pkg::PROD_W-1:0]    prod;
  logic [ret_pkg::COL_W-1:0]     start_nxt;
  logic [ret_pkg::COL_W-1:0]     center_nxt;
  logic [ret_pkg::CNT_W-1:0]     lbase;
  logic [ret_pkg::CNT_W-1:0]     rbase;
  logic [ret_pkg::CNT_W-1:0]     lhits_nxt;
  logic [ret_pkg::CNT_W-1:0]     rhits_nxt;
  logic                          out_free;
  logic                          fc_we;

  // The block takes pixels only between scans.
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Rows outside the frame are ignored entirely; columns outside the row drop the
  // pixel, but a row end on such a transaction still starts the scan.
  assign row_ok  = (32'(in_data.row_index) < 32'(ret_pkg::IMG_HEIGHT));
  assign col_ok  = (32'(in_data.column) < 32'(ret_pkg::IMG_WIDTH));
  assign wr_en   = in_acc & row_ok & col_ok;
  assign wr_addr = in_data.row_index[0]
                 ? ret_pkg::STORE_AW'(ret_pkg::IMG_WIDTH) + ret_pkg::STORE_AW'(in_data.column)
                 : ret_pkg::STORE_AW'(in_data.column);

  // A step of zero behaves as a step of one.
  assign step_eff = (step_cfg_r == '0) ? ret_pkg::STEP_W'(1) : step_cfg_r;

  // Scan addressing. The left scan compares col with col - step - 1, the right scan
  // compares col with col + step + 1; the right scan stops while the far pixel is
  // still inside the row.
  assign step_ext   = ret_pkg::SCAN_W'(step_r);
  assign gap        = step_ext + ret_pkg::SCAN_W'(1);
  assign left_more  = (c_r >= gap);
  assign right_more = ((c_r + gap) <= ret_pkg::SCAN_W'(ret_pkg::LAST_COL));
  assign col_b      = (state_r == S_RRD) ? (c_r + gap) : (c_r - gap);
  assign bank_base  = bank_r ? ret_pkg::STORE_AW'(ret_pkg::IMG_WIDTH) : '0;
  assign rd_addr_a  = bank_base + ret_pkg::STORE_AW'(c_r);
  assign rd_addr_b  = bank_base + ret_pkg::STORE_AW'(col_b);

  // Row buffer: one write port for the pixel stream, two registered read ports
  // for the pair under test.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= in_data.pixel;
    end
    rd_a_r <= store_mem[rd_addr_a];
    rd_b_r <= store_mem[rd_addr_b];
  end

  // The one edge comparator, shared by both scans.
  ret_edge_cmp u_cmp (
    .pix_a (rd_a_r),
    .pix_b (rd_b_r),
    .thr   (thr_r),
    .hit   (edge_hit)
  );

  // Centers of the previous frame, one per row. A row not yet written this far
  // reads as zero through its valid bit.
  assign out_free = ~out_valid_r | ~out_stall;
  assign fc_we    = (state_r == S_DONE) & out_free;

  always_ff @(posedge clk) begin
    if (fc_we) begin
      fc_mem[row_r[ret_pkg::FC_AW-1:0]] <= center_nxt;
    end
    fc_rd_r <= fc_mem[row_r[ret_pkg::FC_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_vld_r <= '0;
    end else if (fc_we) begin
      fc_vld_r[row_r[ret_pkg::FC_AW-1:0]] <= 1'b1;
    end
  end

  // Start column: (4 * old center + 3 * previous start + width) / 10. The sum is
  // registered before the reciprocal multiply.
  assign fc_eff  = fc_hit_r ? fc_rd_r : '0;
  assign sum_nxt = (ret_pkg::SUM_W'(fc_eff) << 2) + (ret_pkg::SUM_W'(start_r) << 1)
                 + ret_pkg::SUM_W'(start_r) + ret_pkg::SUM_W'(ret_pkg::IMG_WIDTH);
  assign prod      = ret_pkg::PROD_W'(sum_r) * ret_pkg::PROD_W'(ret_pkg::DIV_MUL);
  assign start_nxt = ret_pkg::COL_W'(prod >> ret_pkg::DIV_SH);

  assign center_nxt = ret_pkg::COL_W'((ret_pkg::SCAN_W'(left_r) + ret_pkg::SCAN_W'(right_r)) >> 1);

  // The bottom row opens a new frame, so its counts start from zero.
  assign lbase     = bottom_r ? '0 : lhits_r;
  assign rbase     = bottom_r ? '0 : rhits_r;
  assign lhits_nxt = (lf_r && (lbase != ret_pkg::CNT_MAX)) ? lbase + 1'b1 : lbase;
  assign rhits_nxt = (rf_r && (rbase != ret_pkg::CNT_MAX)) ? rbase + 1'b1 : rbase;

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= ret_pkg::THR_RESET;
      step_cfg_r  <= ret_pkg::STEP_RESET;
      start_r     <= ret_pkg::MID_COL;
      lhits_r     <= '0;
      rhits_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (ret_pkg::cfg_idx_t'(cfg_idx))
          ret_pkg::CFG_THRESHOLD: thr_r      <= cfg_wdata[ret_pkg::THR_W-1:0];
          ret_pkg::CFG_STEP:      step_cfg_r <= cfg_wdata[ret_pkg::STEP_W-1:0];
        endcase
      end

      // In the posting state the output register is reloaded below instead.
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          // Row zero stores its pixels but produces no result.
          if (in_acc && row_ok && in_data.row_last && (in_data.row_index != '0)) begin
            row_r    <= in_data.row_index;
            bank_r   <= in_data.row_index[0];
            bottom_r <= (in_data.row_index == ret_pkg::BOTTOM_ROW);
            step_r   <= step_eff;
            state_r  <= S_FC;
          end
        end
        S_FC: begin
          fc_hit_r <= fc_vld_r[row_r[ret_pkg::FC_AW-1:0]];
          state_r  <= S_SUM;
        end
        S_SUM: begin
          sum_r   <= sum_nxt;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (bottom_r) begin
            start_r <= ret_pkg::MID_COL;
            c_r     <= ret_pkg::SCAN_W'(ret_pkg::MID_COL);
          end else begin
            start_r <= start_nxt;
            c_r     <= ret_pkg::SCAN_W'(start_nxt);
          end
          state_r <= S_LRD;
        end
        S_LRD: begin
          if (left_more) begin
            state_r <= S_LCMP;
          end else begin
            left_r  <= '0;
            lf_r    <= 1'b0;
            c_r     <= ret_pkg::SCAN_W'(start_r);
            state_r <= S_RRD;
          end
        end
        S_LCMP: begin
          if (edge_hit) begin
            left_r  <= ret_pkg::COL_W'(c_r - step_ext);
            lf_r    <= 1'b1;
            c_r     <= ret_pkg::SCAN_W'(start_r);
            state_r <= S_RRD;
          end else begin
            c_r     <= c_r - step_ext;
            state_r <= S_LRD;
          end
        end
        S_RRD: begin
          if (right_more) begin
            state_r <= S_RCMP;
          end else begin
            right_r <= ret_pkg::LAST_COL;
            rf_r    <= 1'b0;
            state_r <= S_DONE;
          end
        end
        S_RCMP: begin
          if (edge_hit) begin
            right_r <= ret_pkg::COL_W'(c_r + step_ext);
            rf_r    <= 1'b1;
            state_r <= S_DONE;
          end else begin
            c_r     <= c_r + step_ext;
            state_r <= S_RRD;
          end
        end
        S_DONE: begin
          // Hold here until the output register can take the transaction.
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.out_row     <= row_r;
            out_data_r.left_edge   <= left_r;
            out_data_r.right_edge  <= right_r;
            out_data_r.center      <= center_nxt;
            out_data_r.left_found  <= lf_r;
            out_data_r.right_found <= rf_r;
            out_data_r.left_count  <= lhits_nxt;
            out_data_r.right_count <= rhits_nxt;
            lhits_r                <= lhits_nxt;
            rhits_r                <= rhits_nxt;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A new result only ever comes out of the posting state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished scan");

  // The right scan never compares a pixel past the end of the row.
  a_right_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RCMP) |-> ((c_r + gap) <= ret_pkg::SCAN_W'(ret_pkg::LAST_COL)))
    else $error("right scan read beyond the row");

  // A found left edge never lies at column zero.
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.left_found) |-> (out_data_r.left_edge != '0))
    else $error("found left edge at column zero");

  // A found right edge lies short of the last column.
  a_right_short: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.right_found) |->
      (out_data_r.right_edge < ret_pkg::LAST_COL))
    else $error("found right edge at or past the last column");

  // A found edge is always reflected in the frame counts.
  a_counts_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.left_found || out_data_r.right_found)) |->
      ((out_data_r.left_count != '0) || (out_data_r.right_count != '0)))
    else $error("edge found but frame count is zero");
`endif

endmodule

>>> verif/row_edge_tracker_top_tb.sv
`timescale 1ns / 100ps

module row_edge_tracker_top_tb;

  // Extra wait after the owed reports are in, sized as a full scan: the start
  // column set-up, a row buffer read and a comparison per position at the
  // smallest step, and some margin on top.
  localparam int SCAN_DRAIN = 8 + 2 * ret_pkg::IMG_WIDTH + 16;

  // Random phases. One of them keeps away from the bottom row and sends bare
  // row ends, so the per-frame edge tallies carry on from earlier rows;
  // another one runs a longer stretch with no idle cycles on either side.
  localparam int NUM_PHASES  = 6;
  localparam int SAT_PHASE   = 5;
  localparam int BUSY_PHASE  = 2;
  localparam int FRAME_ROWS  = 2;
  localparam int BUSY_ROWS   = 10;
  localparam int SAT_ROWS    = 6;

  // Noise bits above the step field in a configuration write.
  localparam int JUNK_W = ret_pkg::CFG_DATA_W - ret_pkg::STEP_W;

  // One line of the directed walk. Where typed is set, want holds a result
  // written down by hand; otherwise the expectation comes from the predictor.
  typedef struct packed {
    ret_pkg::in_t  px;
    logic          typed;
    ret_pkg::out_t want;
  } walk_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  ret_pkg::in_t                   in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  ret_pkg::out_t                  out_data;
  logic                           cfg_we = 1'b0;
  logic [ret_pkg::CFG_IDX_W-1:0]  cfg_idx = ret_pkg::CFG_THRESHOLD;
  logic [ret_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state: both row banks, last frame's centers, the running start
  // column, the edge tallies and the two configuration registers.
  logic [ret_pkg::PIX_W-1:0]  line_mem [ret_pkg::STORE_DEPTH];
  logic [ret_pkg::COL_W-1:0]  prior_centers [ret_pkg::IMG_HEIGHT];
  logic [ret_pkg::COL_W-1:0]  seed_col;
  logic [ret_pkg::CNT_W-1:0]  left_tally;
  logic [ret_pkg::CNT_W-1:0]  right_tally;
  logic [ret_pkg::THR_W-1:0]  cur_threshold;
  logic [ret_pkg::STEP_W-1:0] cur_step;

  // Edge reports that the block still owes, oldest first.
  ret_pkg::out_t edge_results_q [$];

  walk_row_t walk_tbl [12];
  int        fail_count = 0;
  int        in_idle_pct = 23;
  int        out_idle_pct = 23;

  row_edge_tracker_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Integer form of the difference over sum test: an edge when the scaled
  // difference exceeds the threshold share of the pixel sum. A dark pair sums
  // to zero and can never pass.
  function automatic bit is_ratio_edge(input int a, input int b);
    int d;
    d = (a > b) ? a - b : b - a;
    return (d * 256) > (int'(cur_threshold) * (a + b));
  endfunction

  // Stores an in-frame pixel and, on a row end of any row but zero, runs both
  // scans. Returns 1 when the transaction produces an edge report, which is then left in res.
  function automatic bit track_row_edges(input ret_pkg::in_t px, output ret_pkg::out_t res);
    int base, seed, stp, c, lft, rgt;
    bit lf, rf;
    res = '0;
    lf = 1'b0;
    rf = 1'b0;
    if (px.row_index >= ret_pkg::IMG_HEIGHT) return 1'b0;
    base = px.row_index[0] ? ret_pkg::IMG_WIDTH : 0;
    if (px.column < ret_pkg::IMG_WIDTH) line_mem[base + px.column] = px.pixel;
    if (!px.row_last || px.row_index == '0) return 1'b0;

    if (px.row_index == ret_pkg::BOTTOM_ROW) begin
      left_tally = '0;
      right_tally = '0;
      seed = ret_pkg::IMG_WIDTH / 2;
    end else begin
      seed = (4 * prior_centers[px.row_index] + 3 * seed_col + ret_pkg::IMG_WIDTH) / 10;
    end
    seed_col = ret_pkg::COL_W'(seed);
    stp = (cur_step == '0) ? 1 : int'(cur_step);

    lft = 0;
    for (c = seed; c >= stp + 1; c -= stp) begin
      if (is_ratio_edge(line_mem[base + c], line_mem[base + c - stp - 1])) begin
        lft = c - stp;
        lf = 1'b1;
        break;
      end
    end
    // The right scan stops while the far pixel is still inside the row.
    rgt = ret_pkg::IMG_WIDTH - 1;
    for (c = seed; c + stp + 1 <= ret_pkg::IMG_WIDTH - 1; c += stp) begin
      if (is_ratio_edge(line_mem[base + c], line_mem[base + c + stp + 1])) begin
        rgt = c + stp;
        rf = 1'b1;
        break;
      end
    end

    if (lf && left_tally != ret_pkg::CNT_MAX) left_tally++;
    if (rf && right_tally != ret_pkg::CNT_MAX) right_tally++;
    prior_centers[px.row_index] = ret_pkg::COL_W'((lft + rgt) >> 1);

    res.out_row     = px.row_index;
    res.left_edge   = ret_pkg::COL_W'(lft);
    res.right_edge  = ret_pkg::COL_W'(rgt);
    res.center      = ret_pkg::COL_W'((lft + rgt) >> 1);
    res.left_found  = lf;
    res.right_found = rf;
    res.left_count  = left_tally;
    res.right_count = right_tally;
    return 1'b1;
  endfunction

  function automatic ret_pkg::in_t make_px(input int pixel, input int col, input int row,
                                           input bit last);
    ret_pkg::in_t px;
    px.pixel     = ret_pkg::PIX_W'(pixel);
    px.column    = ret_pkg::COL_W'(col);
    px.row_index = ret_pkg::ROW_W'(row);
    px.row_last  = last;
    return px;
  endfunction

  // Offers one pixel transaction after a random number of idle cycles and
  // returns at the edge that accepts it. Valid is only lowered for an idle
  // cycle, so back-to-back transactions keep it high.
  task automatic push_pixel(input ret_pkg::in_t px, input bit typed = 1'b0,
                            input ret_pkg::out_t want = '0);
    ret_pkg::out_t res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    if (track_row_edges(px, res)) edge_results_q.push_back(typed ? want : res);
  endtask

  // Brings the block to rest: all owed reports in, then a further SCAN_DRAIN
  // wait; a row end that reports nothing starts no scan.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (edge_results_q.size() != 0) @(posedge clk);
    repeat (SCAN_DRAIN) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges. The step register only keeps
  // the low bits, so the upper bits of the data carry noise.
  task automatic write_config(input logic [ret_pkg::THR_W-1:0] thr,
                              input logic [ret_pkg::STEP_W-1:0] stp);
    logic [JUNK_W-1:0] junk;
    junk = JUNK_W'($urandom_range(15));
    cfg_we    <= 1'b1;
    cfg_idx   <= ret_pkg::CFG_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_idx   <= ret_pkg::CFG_STEP;
    cfg_wdata <= {junk, stp};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_threshold = thr;
    cur_step = stp;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // The receiver stalls at random, except in the phase without idling.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // Every accepted report is matched against the oldest one owed.
  always @(posedge clk) begin : report_check
    ret_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (edge_results_q.size() == 0) begin
        $error("report for row %0d arrived with none owed", out_data.out_row);
        fail_count++;
      end else begin
        want = edge_results_q.pop_front();
        check_field("out_row", want.out_row, out_data.out_row);
        check_field("left_edge", want.left_edge, out_data.left_edge);
        check_field("right_edge", want.right_edge, out_data.right_edge);
        check_field("center", want.center, out_data.center);
        check_field("left_found", want.left_found, out_data.left_found);
        check_field("right_found", want.right_found, out_data.right_found);
        check_field("left_count", want.left_count, out_data.left_count);
        check_field("right_count", want.right_count, out_data.right_count);
      end
    end
  end

  initial begin : stimulus
    int   frame_row, row, phase, r, k, n, mode, col0, rows_in_phase;
    bit   sat;
    logic [ret_pkg::PIX_W-1:0] val;
    logic [ret_pkg::THR_W-1:0] thr;
    logic [ret_pkg::STEP_W-1:0] stp;

    foreach (prior_centers[i]) prior_centers[i] = '0;
    seed_col      = ret_pkg::MID_COL;
    left_tally    = '0;
    right_tally   = '0;
    cur_threshold = ret_pkg::THR_RESET;
    cur_step      = ret_pkg::STEP_RESET;

    // The directed walk runs with the reset settings: threshold 17, step 3.
    // Both banks are filled with a flat grey first, so the first row ends
    // find no edge at all and their reports can be written down directly.
    walk_tbl = '{
      // Bottom row on a flat bank: no edges, tallies cleared.
      '{'{8'd100, 8'd187, 7'd119, 1'b1}, 1'b1,
        '{7'd119, 8'd0, 8'd187, 8'd93, 1'b0, 1'b0, 7'd0, 7'd0}},
      '{'{8'd100, 8'd0, 7'd118, 1'b1}, 1'b1,
        '{7'd118, 8'd0, 8'd187, 8'd93, 1'b0, 1'b0, 7'd0, 7'd0}},
      // Rows beyond the frame are dropped whole, row end or not.
      '{'{8'd255, 8'd255, 7'd127, 1'b1}, 1'b0, '0},
      '{'{8'd0, 8'd0, 7'd120, 1'b1}, 1'b0, '0},
      // Row zero is stored but never reported.
      '{'{8'd100, 8'd0, 7'd0, 1'b1}, 1'b0, '0},
      // A column past the row loses its pixel, yet its row end still scans.
      '{'{8'd7, 8'd200, 7'd117, 1'b1}, 1'b1,
        '{7'd117, 8'd0, 8'd187, 8'd93, 1'b0, 1'b0, 7'd0, 7'd0}},
      // Row 116 starts at column 28. Its first left comparison pairs two
      // dark pixels, whose sum is zero, and the bright one further left
      // gives the edge. The right scan leaves the dark pixel at once.
      '{'{8'd0, 8'd24, 7'd116, 1'b0}, 1'b0, '0},
      '{'{8'd0, 8'd28, 7'd116, 1'b0}, 1'b0, '0},
      '{'{8'd255, 8'd10, 7'd116, 1'b0}, 1'b0, '0},
      '{'{8'd100, 8'd187, 7'd116, 1'b1}, 1'b0, '0},
      // Lowest row that reports, with a bright pixel in column zero.
      '{'{8'd255, 8'd0, 7'd1, 1'b1}, 1'b0, '0},
      // A dark pixel in the last column of the other bank.
      '{'{8'd0, 8'd187, 7'd115, 1'b1}, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Fill both banks so that no scan ever reads a location never written.
    for (int b = 0; b < 2; b++) begin
      for (int c = 0; c < ret_pkg::IMG_WIDTH; c++) push_pixel(make_px(100, c, b, 1'b0));
    end

    foreach (walk_tbl[i]) push_pixel(walk_tbl[i].px, walk_tbl[i].typed, walk_tbl[i].want);

    // Random phases. Most rows follow the frame order from the bottom row
    // upward, most of them touching a few stored pixels before their row end so
    // that the banks keep changing. Now and then a stray transaction with
    // any row and column slips in between.
    frame_row = ret_pkg::IMG_HEIGHT - 1;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle_block();
      case (phase)
        0:         begin thr = 8'd0;   stp = 4'd1;  end
        1:         begin thr = 8'd255; stp = 4'd8;  end
        2:         begin thr = 8'd17;  stp = 4'd0;  end
        3:         begin thr = 8'd90;  stp = 4'd15; end
        SAT_PHASE: begin thr = 8'd0;   stp = ret_pkg::STEP_W'($urandom_range(1, 8)); end
        default: begin
          thr = ret_pkg::THR_W'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                         : $urandom_range(40));
          stp = ret_pkg::STEP_W'($urandom_range(1, 8));
        end
      endcase
      write_config(thr, stp);
      in_idle_pct  = (phase == BUSY_PHASE) ? 0 : 23;
      out_idle_pct = (phase == BUSY_PHASE) ? 0 : 23;
      sat = (phase == SAT_PHASE);
      rows_in_phase = sat ? SAT_ROWS : ((phase == BUSY_PHASE) ? BUSY_ROWS : FRAME_ROWS);

      for (r = 0; r < rows_in_phase; r++) begin
        if (sat) begin
          // Stay off the bottom row so the tallies are never cleared.
          row = $urandom_range(1, ret_pkg::IMG_HEIGHT - 2);
        end else begin
          row = frame_row;
          frame_row = (frame_row == 0) ? ret_pkg::IMG_HEIGHT - 1 : frame_row - 1;
          if ($urandom_range(9) == 0) begin
            push_pixel(make_px($urandom_range(255), $urandom_range(255),
                               $urandom_range(127), 1'($urandom_range(1))));
          end
        end

        mode = sat ? 3 : $urandom_range(3);
        case (mode)
          0: begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
              push_pixel(make_px($urandom_range(255),
                                 $urandom_range(ret_pkg::IMG_WIDTH - 1), row, 1'b0));
            end
          end
          1: begin
            // A short run of equal pixels: dark, bright or any grey.
            col0 = $urandom_range(ret_pkg::IMG_WIDTH - 1);
            n = $urandom_range(1, 8);
            case ($urandom_range(2))
              0:       val = '0;
              1:       val = '1;
              default: val = ret_pkg::PIX_W'($urandom_range(255));
            endcase
            for (k = 0; k < n && col0 + k < ret_pkg::IMG_WIDTH; k++) begin
              push_pixel(make_px(val, col0 + k, row, 1'b0));
            end
          end
          2: begin
            // Near-flat values, mostly too weak to pass the threshold.
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
              push_pixel(make_px($urandom_range(90, 110),
                                 $urandom_range(ret_pkg::IMG_WIDTH - 1), row, 1'b0));
            end
          end
          default: ;
        endcase

        push_pixel(make_px($urandom_range(255), $urandom_range(255), row, 1'b1));
      end
    end

    settle_block();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Safety net: the slowest correct run is well under a quarter of this.
  initial begin : watchdog
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
